/* rtl/skdh_pkg.sv */
// Shared types and constants for the string-key double-hash table.
// Holds the request/result structs, the controller state encoding and the
// controller-to-datapath command and status groups. No dependencies.
package skdh_pkg;

  localparam int unsigned OCC_W  = 20;
  localparam int unsigned COLL_W = 32;
  localparam logic [OCC_W-1:0]  OCC_MAX  = '1;
  localparam logic [COLL_W-1:0] COLL_MAX = '1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [OCC_W-1:0]  occurrences;
    logic [9:0]        slot;
    logic [9:0]        distinct_keys;
    logic [COLL_W-1:0] collision_total;
    logic [1:0]        status;
  } out_t;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_REDUCE   = 10'b00_0000_0100,
    S_PRB_RD   = 10'b00_0000_1000,
    S_PRB_EVAL = 10'b00_0001_0000,
    S_CMP_RD   = 10'b00_0010_0000,
    S_CMP_CHK  = 10'b00_0100_0000,
    S_CPY_RD   = 10'b00_1000_0000,
    S_CPY_WR   = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic reduce;
    logic probe_start;
    logic meta_rd;
    logic ins_new;
    logic advance;
    logic cmp_start;
    logic rd_chars;
    logic hit;
    logic cpy_wr;
    logic j_inc;
    logic res_long;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_ready;
    logic last_item;
    logic too_long;
    logic occupied;
    logic len_eq;
    logic is_lookup;
    logic last_probe;
    logic char_eq;
    logic j_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/skdh_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the key store, slot metadata and key buffer. No dependencies.
module skdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/skdh_ctrl.sv */
// Controller state machine for the double-hash table.
// Sequences hashing, probing, key compare and key copy; uses skdh_pkg.
module skdh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  skdh_pkg::sts_t sts,
  output skdh_pkg::cmd_t cmd
);

  skdh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skdh_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != skdh_pkg::S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      skdh_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = skdh_pkg::S_IDLE;
      end
      skdh_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = skdh_pkg::S_REDUCE;
        end
      end
      skdh_pkg::S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.hash_ready) begin
          if (!sts.last_item) begin
            state_nxt = skdh_pkg::S_IDLE;
          end else if (sts.too_long) begin
            cmd.res_long = 1'b1;
            state_nxt    = skdh_pkg::S_FINISH;
          end else begin
            cmd.probe_start = 1'b1;
            state_nxt       = skdh_pkg::S_PRB_RD;
          end
        end
      end
      skdh_pkg::S_PRB_RD: begin
        cmd.meta_rd = 1'b1;
        state_nxt   = skdh_pkg::S_PRB_EVAL;
      end
      skdh_pkg::S_PRB_EVAL: begin
        if (!sts.occupied) begin
          if (sts.is_lookup) begin
            state_nxt = skdh_pkg::S_FINISH;
          end else begin
            cmd.ins_new = 1'b1;
            state_nxt   = skdh_pkg::S_CPY_RD;
          end
        end else if (sts.len_eq) begin
          cmd.cmp_start = 1'b1;
          state_nxt     = skdh_pkg::S_CMP_RD;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = sts.last_probe ? skdh_pkg::S_FINISH : skdh_pkg::S_PRB_RD;
        end
      end
      skdh_pkg::S_CMP_RD: begin
        cmd.rd_chars = 1'b1;
        state_nxt    = skdh_pkg::S_CMP_CHK;
      end
      skdh_pkg::S_CMP_CHK: begin
        if (!sts.char_eq) begin
          cmd.advance = 1'b1;
          state_nxt   = sts.last_probe ? skdh_pkg::S_FINISH : skdh_pkg::S_PRB_RD;
        end else if (sts.j_last) begin
          cmd.hit   = 1'b1;
          state_nxt = skdh_pkg::S_FINISH;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = skdh_pkg::S_CMP_RD;
        end
      end
      skdh_pkg::S_CPY_RD: begin
        cmd.rd_chars = 1'b1;
        state_nxt    = skdh_pkg::S_CPY_WR;
      end
      skdh_pkg::S_CPY_WR: begin
        cmd.cpy_wr = 1'b1;
        if (sts.j_last) begin
          state_nxt = skdh_pkg::S_FINISH;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = skdh_pkg::S_CPY_RD;
        end
      end
      skdh_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = skdh_pkg::S_IDLE;
        end
      end
      default: state_nxt = skdh_pkg::S_CLEAR;
    endcase
  end

endmodule

/* rtl/skdh_dp.sv */
// Datapath for the double-hash table: hash registers, probe index, counters,
// result register and the three RAMs. Uses skdh_pkg and skdh_ram.
module skdh_dp #(
  parameter int unsigned TABLE_SIZE    = 1021,
  parameter int unsigned MAX_KEY_CHARS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  skdh_pkg::in_t  in_data,
  input  logic           out_stall,
  output logic           out_valid,
  output skdh_pkg::out_t out_data,
  input  skdh_pkg::cmd_t cmd,
  output skdh_pkg::sts_t sts
);

  localparam int unsigned SLOT_W   = $clog2(TABLE_SIZE);
  localparam int unsigned SUM_W    = ((SLOT_W > 8) ? SLOT_W : 8) + 1;
  localparam int unsigned LEN_W    = $clog2(MAX_KEY_CHARS + 1);
  localparam int unsigned JW       = $clog2(MAX_KEY_CHARS);
  localparam int unsigned DIST_W   = $clog2(TABLE_SIZE + 1);
  localparam int unsigned KS_DEPTH = TABLE_SIZE * MAX_KEY_CHARS;
  localparam int unsigned KS_AW    = $clog2(KS_DEPTH);
  localparam int unsigned META_W   = 1 + LEN_W + skdh_pkg::OCC_W;

  localparam logic [SUM_W-1:0]    T_SUM   = SUM_W'(TABLE_SIZE);
  localparam logic [SUM_W-1:0]    TM1_SUM = SUM_W'(TABLE_SIZE - 1);
  localparam logic [SLOT_W:0]     T_K     = (SLOT_W + 1)'(TABLE_SIZE);
  localparam logic [SLOT_W-1:0]   T_LAST  = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [LEN_W-1:0]    M_LEN   = LEN_W'(MAX_KEY_CHARS);
  localparam logic [KS_AW-1:0]    M_KS    = KS_AW'(MAX_KEY_CHARS);

  logic [LEN_W-1:0]  len_r;
  logic [SUM_W-1:0]  p_r, s_r;
  logic              raw_r, too_long_r, last_r, mode_r;
  logic [SLOT_W-1:0] k_r, probes_r;
  logic [KS_AW-1:0]  kbase_r;
  logic [JW-1:0]     j_r;
  logic [DIST_W-1:0] dist_r;
  logic [skdh_pkg::COLL_W-1:0] coll_r;
  logic              res_found_r;
  logic [skdh_pkg::OCC_W-1:0] res_occ_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r;
  skdh_pkg::out_t    out_r;

  logic [META_W-1:0] meta_rdata, meta_wdata;
  logic              meta_we;
  logic [7:0]        kbuf_rdata, ks_rdata;
  logic              m_occ;
  logic [LEN_W-1:0]  m_len;
  logic [skdh_pkg::OCC_W-1:0] m_cnt, hit_cnt;
  logic              hit_bump;
  logic [SLOT_W:0]   k_sum;
  logic [SLOT_W-1:0] k_step;
  logic [KS_AW-1:0]  ks_addr;
  logic              p_in, s_in;

  assign m_occ    = meta_rdata[META_W-1];
  assign m_len    = meta_rdata[META_W-2 -: LEN_W];
  assign m_cnt    = meta_rdata[skdh_pkg::OCC_W-1:0];
  assign hit_bump = (mode_r == skdh_pkg::MODE_INSERT) && (m_cnt != skdh_pkg::OCC_MAX);
  assign hit_cnt  = hit_bump ? m_cnt + 1'b1 : m_cnt;

  assign k_sum   = (SLOT_W + 1)'(k_r) + (SLOT_W + 1)'(s_r);
  assign k_step  = (k_sum >= T_K) ? SLOT_W'(k_sum - T_K) : k_sum[SLOT_W-1:0];
  assign ks_addr = KS_AW'(kbase_r + KS_AW'(j_r));

  assign p_in = (p_r < T_SUM);
  assign s_in = (s_r < TM1_SUM);

  assign sts.clr_last   = (k_r == T_LAST);
  assign sts.hash_ready = !raw_r || (p_in && s_in);
  assign sts.last_item  = last_r;
  assign sts.too_long   = too_long_r;
  assign sts.occupied   = m_occ;
  assign sts.len_eq     = (m_len == len_r);
  assign sts.is_lookup  = (mode_r == skdh_pkg::MODE_LOOKUP);
  assign sts.last_probe = (probes_r == T_LAST);
  assign sts.char_eq    = (kbuf_rdata == ks_rdata);
  assign sts.j_last     = (LEN_W'(j_r) == len_r - 1'b1);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    meta_we    = cmd.clr_wr || cmd.ins_new || (cmd.hit && hit_bump);
    meta_wdata = '0;
    if (cmd.ins_new) begin
      meta_wdata = {1'b1, len_r, skdh_pkg::OCC_W'(1)};
    end else if (cmd.hit) begin
      meta_wdata = {1'b1, m_len, hit_cnt};
    end
  end

  skdh_ram #(.WIDTH(META_W), .DEPTH(TABLE_SIZE)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (k_r),
    .wdata (meta_wdata),
    .re    (cmd.meta_rd),
    .raddr (k_r),
    .rdata (meta_rdata)
  );

  skdh_ram #(.WIDTH(8), .DEPTH(MAX_KEY_CHARS)) u_kbuf (
    .clk   (clk),
    .we    (cmd.accept && (len_r < M_LEN)),
    .waddr (len_r[JW-1:0]),
    .wdata (in_data.key_char),
    .re    (cmd.rd_chars),
    .raddr (j_r),
    .rdata (kbuf_rdata)
  );

  skdh_ram #(.WIDTH(8), .DEPTH(KS_DEPTH)) u_kstore (
    .clk   (clk),
    .we    (cmd.cpy_wr),
    .waddr (ks_addr),
    .wdata (kbuf_rdata),
    .re    (cmd.rd_chars),
    .raddr (ks_addr),
    .rdata (ks_rdata)
  );

  // Key assembly and hash reduction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      p_r        <= '0;
      s_r        <= '0;
      raw_r      <= 1'b0;
      too_long_r <= 1'b0;
      last_r     <= 1'b0;
      mode_r     <= 1'b0;
    end else if (cmd.emit) begin
      len_r      <= '0;
      p_r        <= '0;
      s_r        <= '0;
      raw_r      <= 1'b0;
      too_long_r <= 1'b0;
    end else if (cmd.accept) begin
      last_r <= in_data.last_char;
      mode_r <= in_data.mode;
      if (len_r < M_LEN) begin
        len_r <= len_r + 1'b1;
        p_r   <= p_r + SUM_W'(in_data.key_char);
        s_r   <= s_r + SUM_W'(in_data.key_char);
        raw_r <= 1'b1;
      end else begin
        too_long_r <= 1'b1;
      end
    end else if (cmd.reduce && raw_r) begin
      if (!p_in) p_r <= p_r - T_SUM;
      if (!s_in) s_r <= s_r - TM1_SUM;
      if (p_in && s_in) begin
        s_r   <= s_r + 1'b1;
        raw_r <= 1'b0;
      end
    end
  end

  // Probe sequencing; k_r doubles as the clear-pass index after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      probes_r <= '0;
      j_r      <= '0;
    end else begin
      if (cmd.clr_wr) begin
        k_r <= k_r + 1'b1;
      end else if (cmd.probe_start) begin
        k_r      <= p_r[SLOT_W-1:0];
        probes_r <= '0;
      end else if (cmd.advance) begin
        k_r      <= k_step;
        probes_r <= probes_r + 1'b1;
      end
      if (cmd.ins_new || cmd.cmp_start) begin
        j_r <= '0;
      end else if (cmd.j_inc) begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.meta_rd) begin
      kbase_r <= KS_AW'(KS_AW'(k_r) * M_KS);
    end
  end

  // Running totals and the per-key result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      coll_r <= '0;
    end else begin
      if (cmd.ins_new) dist_r <= dist_r + 1'b1;
      if (cmd.advance && (mode_r == skdh_pkg::MODE_INSERT) && (coll_r != skdh_pkg::COLL_MAX)) begin
        coll_r <= coll_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_start || cmd.res_long) begin
      res_found_r  <= 1'b0;
      res_occ_r    <= '0;
      res_slot_r   <= '0;
      res_status_r <= cmd.res_long ? skdh_pkg::ST_TOO_LONG : skdh_pkg::ST_OK;
    end else if (cmd.ins_new) begin
      res_occ_r  <= skdh_pkg::OCC_W'(1);
      res_slot_r <= k_r;
    end else if (cmd.hit) begin
      res_found_r <= 1'b1;
      res_occ_r   <= hit_cnt;
      res_slot_r  <= k_r;
    end else if (cmd.advance && sts.last_probe) begin
      res_status_r <= skdh_pkg::ST_FULL;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.found           <= res_found_r;
      out_r.occurrences     <= res_occ_r;
      out_r.slot            <= 10'(res_slot_r);
      out_r.distinct_keys   <= 10'(dist_r);
      out_r.collision_total <= coll_r;
      out_r.status          <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/string_key_double_hash_table_core.sv */
// String-key hash table with double hashing. Keys arrive one character per
// request; each character is accepted and then its hashes are reduced, the
// reduction repeating while either hash still needs a modulo subtraction.
// On the last character of a key that fits, the table is probed: each
// probed slot's metadata is read and then evaluated, each character compared
// against a stored key of equal length is read and then checked, and each
// character copied for a new key is read and then written; the result is
// then handed over, later while the result register is held by a stalled
// result. These read-then-use steps come from the single read port of the
// key and metadata RAMs. After reset a clearing pass writes every slot of the
// metadata RAM before the first request is taken.
module string_key_double_hash_table_core #(
  parameter int unsigned TABLE_SIZE    = 1021,
  parameter int unsigned MAX_KEY_CHARS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  skdh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output skdh_pkg::out_t out_data
);

  skdh_pkg::cmd_t cmd;
  skdh_pkg::sts_t sts;

  skdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  skdh_dp #(
    .TABLE_SIZE    (TABLE_SIZE),
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* verif/skdh_checker.sv */
`timescale 1ns / 1ps
// Result checker for the string-key double-hash table: watches the request and
// result channels, predicts each lookup/insert result and compares it field by field.
// Depends on skdh_pkg for the request and result structs and status codes.
module skdh_checker
  import skdh_pkg::*;
#(
  parameter int TABLE_SIZE    = 1021,
  parameter int MAX_KEY_CHARS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fail_count,
  output int   results_waiting,
  output int   results_checked
);

  logic [7:0]        table_chars [TABLE_SIZE][MAX_KEY_CHARS];
  int                table_len   [TABLE_SIZE];
  bit                table_used  [TABLE_SIZE];
  logic [OCC_W-1:0]  table_count [TABLE_SIZE];
  logic [7:0]        key_chars   [MAX_KEY_CHARS];
  int                key_len;
  int                home_hash;
  int                stride_hash;
  bit                key_overflow;
  int                keys_stored;
  logic [COLL_W-1:0] probe_misses;
  out_t              expected_results [$];

  function automatic bit key_in_slot(int s);
    if (table_len[s] != key_len) return 0;
    for (int j = 0; j < key_len; j++)
      if (table_chars[s][j] != key_chars[j]) return 0;
    return 1;
  endfunction

  // Fold one character into the key; returns 1 and fills res on a last char.
  function automatic bit predict_table(input in_t req, output out_t res);
    int  k;
    bit  done;
    res = '0;
    done = 0;
    if (key_len < MAX_KEY_CHARS) begin
      key_chars[key_len] = req.key_char;
      key_len++;
      home_hash   = (home_hash + req.key_char) % TABLE_SIZE;
      stride_hash = 1 + (stride_hash + req.key_char) % (TABLE_SIZE - 1);
    end else begin
      key_overflow = 1;
    end
    if (!req.last_char) return 0;
    if (key_overflow) begin
      res.status = ST_TOO_LONG;
    end else begin
      k = home_hash;
      for (int p = 0; p < TABLE_SIZE && !done; p++) begin
        if (!table_used[k]) begin
          if (req.mode == MODE_INSERT) begin
            table_used[k] = 1;
            table_len[k] = key_len;
            for (int j = 0; j < key_len; j++) table_chars[k][j] = key_chars[j];
            table_count[k] = 1;
            keys_stored++;
            res.occurrences = 1;
            res.slot = k[9:0];
          end
          done = 1;
        end else if (key_in_slot(k)) begin
          if (req.mode == MODE_INSERT && table_count[k] != OCC_MAX)
            table_count[k]++;
          res.found = 1;
          res.occurrences = table_count[k];
          res.slot = k[9:0];
          done = 1;
        end else begin
          if (req.mode == MODE_INSERT && probe_misses != COLL_MAX) probe_misses++;
          k = (k + stride_hash) % TABLE_SIZE;
        end
      end
      res.status = done ? ST_OK : ST_FULL;
    end
    res.distinct_keys = keys_stored[9:0];
    res.collision_total = probe_misses;
    key_len = 0;
    home_hash = 0;
    stride_hash = 0;
    key_overflow = 0;
    return 1;
  endfunction

  always @(posedge clk) begin
    out_t res;
    out_t exp_res;
    if (!rst_n) begin
      foreach (table_used[i]) table_used[i] = 0;
      key_len = 0;
      home_hash = 0;
      stride_hash = 0;
      key_overflow = 0;
      keys_stored = 0;
      probe_misses = '0;
      expected_results.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (in_valid && !in_stall)
        if (predict_table(in_data, res)) expected_results.push_back(res);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none actual %p", $time, out_data);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.found !== exp_res.found) begin
            fail_count++;
            $display("%0t: found expected %0d actual %0d", $time,
                     exp_res.found, out_data.found);
          end
          if (out_data.occurrences !== exp_res.occurrences) begin
            fail_count++;
            $display("%0t: occurrences expected %0d actual %0d", $time,
                     exp_res.occurrences, out_data.occurrences);
          end
          if (out_data.slot !== exp_res.slot) begin
            fail_count++;
            $display("%0t: slot expected %0d actual %0d", $time,
                     exp_res.slot, out_data.slot);
          end
          if (out_data.distinct_keys !== exp_res.distinct_keys) begin
            fail_count++;
            $display("%0t: distinct_keys expected %0d actual %0d", $time,
                     exp_res.distinct_keys, out_data.distinct_keys);
          end
          if (out_data.collision_total !== exp_res.collision_total) begin
            fail_count++;
            $display("%0t: collision_total expected %0d actual %0d", $time,
                     exp_res.collision_total, out_data.collision_total);
          end
          if (out_data.status !== exp_res.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, out_data.status);
          end
        end
      end
    end
    results_waiting = expected_results.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the hash table testbench: clock, reset, character stimulus and
// receiver stalls. Instantiates the core and skdh_checker; uses skdh_pkg.
module testbench;
  import skdh_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   results_waiting;
  int   results_checked;

  logic [7:0] key_buf [128];
  int         key_size;
  logic [7:0] pool_chars [32][8];
  int         pool_len [32];
  int         chars_sent;
  int         keys_sent;
  int         burst_left;

  string_key_double_hash_table_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  skdh_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .results_waiting(results_waiting),
    .results_checked(results_checked)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: phases of no stall, light and heavy stall, plus one long hold.
  initial begin
    int cyc;
    out_stall <= 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 1600 && cyc < 2200)
        out_stall <= 1;
      else
        case ((cyc / 700) % 3)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end
  end

  task automatic send_char(input logic m, input logic [7:0] c, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1;
    in_data <= '{mode: m, key_char: c, last_char: lst};
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  // Send key_buf[0 .. key_size-1]; mode matters only on the last request.
  task automatic send_key(input logic m);
    for (int i = 0; i < key_size; i++)
      send_char((i == key_size - 1) ? m : logic'($urandom_range(0, 1)),
                key_buf[i], i == key_size - 1);
    keys_sent++;
  endtask

  task automatic load_pool(input int p);
    key_size = pool_len[p];
    for (int i = 0; i < key_size; i++) key_buf[i] = pool_chars[p][i];
  endtask

  task automatic load_random(input int n);
    key_size = n;
    for (int i = 0; i < n; i++) key_buf[i] = $urandom_range(1, 255);
  endtask

  initial begin
    int r;
    int lim;
    rst_n <= 0;
    in_valid <= 0;
    in_data <= '0;
    chars_sent = 0;
    keys_sent = 0;
    burst_left = 0;
    for (int p = 0; p < 16; p++) begin
      pool_len[p] = $urandom_range(1, 8);
      for (int i = 0; i < 8; i++) pool_chars[p][i] = $urandom_range(1, 255);
    end
    // reversed copies share the primary hash with their originals: forced collisions
    for (int p = 16; p < 32; p++) begin
      pool_len[p] = pool_len[p - 16];
      for (int i = 0; i < pool_len[p]; i++)
        pool_chars[p][i] = pool_chars[p - 16][pool_len[p] - 1 - i];
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed: extreme characters, miss, insert, repeat, anagram collision
    key_size = 1; key_buf[0] = 8'd1;   send_key(MODE_LOOKUP);
    send_key(MODE_INSERT);
    send_key(MODE_INSERT);
    send_key(MODE_LOOKUP);
    key_buf[0] = 8'd255;               send_key(MODE_INSERT);
    key_size = 2; key_buf[0] = 8'h41; key_buf[1] = 8'h42; send_key(MODE_INSERT);
    key_buf[0] = 8'h42; key_buf[1] = 8'h41; send_key(MODE_LOOKUP);
    send_key(MODE_INSERT);
    send_key(MODE_LOOKUP);
    key_size = 3; key_buf[0] = 8'h80; key_buf[1] = 8'h7F; key_buf[2] = 8'hAA;
    send_key(MODE_INSERT);

    while (chars_sent < 580) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        load_pool($urandom_range(0, 31));
        send_key(($urandom_range(0, 99) < 40) ? MODE_LOOKUP : MODE_INSERT);
      end else if (r < 85) begin
        load_random($urandom_range(1, 12));
        send_key(logic'($urandom_range(0, 1)));
      end else if (r < 91) begin
        load_random($urandom_range(20, 64));
        send_key(logic'($urandom_range(0, 1)));
      end else if (r < 95) begin
        load_random($urandom_range(65, 80));
        send_key(logic'($urandom_range(0, 1)));
      end else begin
        // exactly the longest legal key, inserted then looked up
        load_random(64);
        send_key(MODE_INSERT);
        send_key(MODE_LOOKUP);
      end
    end

    in_valid <= 0;
    lim = 0;
    while (results_waiting != 0 && lim < 2_000_000) begin
      @(posedge clk);
      lim++;
    end
    repeat (200) @(posedge clk);
    $display("sent %0d keys in %0d character requests, %0d results checked",
             keys_sent, chars_sent, results_checked);
    $display("covered repeats, misses, anagram collisions, long keys, output hold");
    if (fail_count == 0 && results_waiting == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
